// ----- hdl/assert_macros.svh -----
// Assertion macros for the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/c2u_pkg.sv -----
// Types, constants and the high-block code point table for the transcoder.
`timescale 1ns / 1ps

package c2u_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] cp_t;
  typedef logic [1:0]  cnt_t;

  localparam byte_t SpaceByte = 8'h20;
  localparam byte_t Lead2     = 8'hC0;
  localparam byte_t Lead3     = 8'hE0;
  localparam byte_t ContByte  = 8'h80;

  localparam cnt_t Len1 = 2'd1;
  localparam cnt_t Len2 = 2'd2;
  localparam cnt_t Len3 = 2'd3;

  // Code points for bytes 0x80..0x9F; zero marks an undefined entry.
  function automatic cp_t high_block_cp(input logic [4:0] idx);
    cp_t cp;
    unique case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = 16'h0000;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h0000;
      5'd14: cp = 16'h017D;
      5'd15: cp = 16'h0000;
      5'd16: cp = 16'h0000;
      5'd17: cp = 16'h2018;
      5'd18: cp = 16'h2019;
      5'd19: cp = 16'h201C;
      5'd20: cp = 16'h201D;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h0000;
      5'd30: cp = 16'h017E;
      5'd31: cp = 16'h0178;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

endpackage

// ----- hdl/cp1252_to_utf8_transcoder.sv -----
// Top level: Windows-1252 byte in, UTF-8 bytes out.
`timescale 1ns / 1ps
//
// Input channel: drive in_byte and in_text_end with start high; the beat is
// taken at a rising edge where start is high and busy is low.
// Output channel: each UTF-8 byte is on out_byte for exactly one cycle with
// out_strobe high. out_run_last marks the last byte of an input beat's run,
// out_text_last marks that byte when in_text_end was set on the beat.
// Timing: the accepting edge loads the run register, and each byte then
// passes through the output register; the bytes of a run come in
// consecutive cycles. Throughput: the single-byte output register takes
// the bytes of a run in turn. busy is high while more than one byte of
// the current run remains, so the next beat is taken while the last byte
// of a run moves to the output register.
// Reset (rst_n low, synchronous) empties the run register and drops the
// strobe; bytes in flight are lost.
// The receiver cannot stall: every strobed byte is taken in its cycle.
//
module cp1252_to_utf8_transcoder
  import c2u_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_byte,
  input  logic       in_text_end,
  output logic       out_strobe,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_last
);

  `include "assert_macros.svh"

  logic       accept;
  cp_t        cp;
  logic       undef_cp;
  byte_t      enc0, enc1, enc2;
  cnt_t       enc_len;

  byte_t      q0_r, q1_r, q2_r;
  byte_t      q0_nxt, q1_nxt, q2_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       end_r, end_nxt;

  logic       strobe_r, strobe_nxt;
  byte_t      obyte_r, obyte_nxt;
  logic       orun_r, orun_nxt;
  logic       otext_r, otext_nxt;

  assign busy   = (cnt_r == Len2) || (cnt_r == Len3);
  assign accept = start && !busy;

  // Encode the incoming byte.
  always_comb begin
    if (in_byte[7:5] == 3'b100) begin
      cp = high_block_cp(in_byte[4:0]);
    end else begin
      cp = {8'h00, in_byte};
    end
    undef_cp = (in_byte[7:5] == 3'b100) && (cp == 16'h0000);
    enc1 = ContByte | {2'b00, cp[5:0]};
    enc2 = ContByte | {2'b00, cp[5:0]};
    priority if (undef_cp) begin
      enc0    = SpaceByte;
      enc_len = Len1;
    end else if (cp[15:7] == 9'd0) begin
      enc0    = cp[7:0];
      enc_len = Len1;
    end else if (cp[15:11] == 5'd0) begin
      enc0    = Lead2 | {3'b000, cp[10:6]};
      enc_len = Len2;
    end else begin
      enc0    = Lead3 | {4'b0000, cp[15:12]};
      enc1    = ContByte | {2'b00, cp[11:6]};
      enc_len = Len3;
    end
  end

  // Load a new run or advance the current one.
  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    q2_nxt  = q2_r;
    cnt_nxt = cnt_r;
    end_nxt = end_r;
    if (accept) begin
      q0_nxt  = enc0;
      q1_nxt  = enc1;
      q2_nxt  = enc2;
      cnt_nxt = enc_len;
      end_nxt = in_text_end;
    end else if (cnt_r != 2'd0) begin
      q0_nxt  = q1_r;
      q1_nxt  = q2_r;
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_comb begin
    strobe_nxt = (cnt_r != 2'd0);
    obyte_nxt  = q0_r;
    orun_nxt   = (cnt_r == Len1);
    otext_nxt  = (cnt_r == Len1) && end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r    <= q0_nxt;
    q1_r    <= q1_nxt;
    q2_r    <= q2_nxt;
    end_r   <= end_nxt;
    obyte_r <= obyte_nxt;
    orun_r  <= orun_nxt;
    otext_r <= otext_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_byte      = obyte_r;
  assign out_run_last  = strobe_r && orun_r;
  assign out_text_last = strobe_r && otext_r;

  `ASSERT_SAME(a_text_last_ends_run, out_text_last, out_run_last, "text_last without run_last")
  `ASSERT_NEXT(a_accept_loads_run, accept, cnt_r != 2'd0, "accepted beat left no bytes")
  `ASSERT_NEXT(a_run_contiguous, out_strobe && !out_run_last, out_strobe, "gap inside a run")
  `ASSERT_ALWAYS(a_busy_only_with_run, !busy || (cnt_r != 2'd0), "busy with empty run")

endmodule

// ----- verif/cp1252_to_utf8_transcoder_tb.sv -----
// Self-checking testbench for the Windows-1252 to UTF-8 transcoder.
`timescale 1ns / 1ps

module cp1252_to_utf8_transcoder_tb;
  import c2u_pkg::*;

  localparam int RandomBytes = 210;
  localparam int CycleLimit  = 40000;
  localparam int TailCycles  = 8;

  typedef struct packed {
    byte_t value;
    logic  text_end;
  } src_beat_t;

  typedef struct packed {
    byte_t data;
    logic  run_last;
    logic  text_last;
  } utf8_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_byte = 8'h00;
  logic       in_text_end = 1'b0;
  logic       out_strobe;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_last;

  src_beat_t  src_pending[$];
  utf8_beat_t utf8_due[$];
  int         errors = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  logic       drive_now;

  cp_t high_cp [0:31] = '{
    16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
    16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
  };

  cp1252_to_utf8_transcoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_byte      (in_byte),
    .in_text_end  (in_text_end),
    .out_strobe   (out_strobe),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_last(out_text_last)
  );

  function automatic void push_utf8(byte_t data, logic run_last, logic text_end);
    utf8_beat_t beat;
    beat.data      = data;
    beat.run_last  = run_last;
    beat.text_last = run_last & text_end;
    utf8_due.push_back(beat);
  endfunction

  function automatic void encode_utf8(src_beat_t src);
    cp_t cp;
    cp = {8'h00, src.value};
    if (src.value >= 8'h80 && src.value <= 8'h9F) begin
      cp = high_cp[src.value[4:0]];
      if (cp == 16'h0000) cp = {8'h00, SpaceByte};
    end
    if (cp < 16'h0080) begin
      push_utf8(cp[7:0], 1'b1, src.text_end);
    end else if (cp < 16'h0800) begin
      push_utf8(Lead2 | {3'b000, cp[10:6]}, 1'b0, src.text_end);
      push_utf8(ContByte | {2'b00, cp[5:0]}, 1'b1, src.text_end);
    end else begin
      push_utf8(Lead3 | {4'h0, cp[15:12]}, 1'b0, src.text_end);
      push_utf8(ContByte | {2'b00, cp[11:6]}, 1'b0, src.text_end);
      push_utf8(ContByte | {2'b00, cp[5:0]}, 1'b1, src.text_end);
    end
  endfunction

  function automatic void add_src(byte_t value, logic text_end);
    src_beat_t beat;
    beat.value    = value;
    beat.text_end = text_end;
    src_pending.push_back(beat);
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    add_src(8'h00, 1'b0);
    add_src(8'h41, 1'b0);
    add_src(8'h7F, 1'b1);
    add_src(8'h00, 1'b1);
    add_src(8'h80, 1'b0);
    add_src(8'h81, 1'b0);
    add_src(8'h8D, 1'b1);
    add_src(8'h8F, 1'b0);
    add_src(8'h90, 1'b0);
    add_src(8'h9D, 1'b1);
    add_src(8'h83, 1'b0);
    add_src(8'h88, 1'b1);
    add_src(8'h99, 1'b0);
    add_src(8'h9F, 1'b1);
    add_src(8'hA0, 1'b0);
    add_src(8'hBF, 1'b0);
    add_src(8'hC0, 1'b1);
    add_src(8'hFF, 1'b0);
    add_src(8'h80, 1'b1);
    add_src(8'h20, 1'b1);
    for (int i = 0; i < RandomBytes; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_src(byte_t'($urandom_range(8'h80, 8'h9F)), $urandom_range(0, 4) == 0);
      end else begin
        add_src(byte_t'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (src_pending.size() != 0 || utf8_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        encode_utf8(src_pending.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      drive_now = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (src_pending.size() != 0) begin
        drive_now = 1'b1;
      end
      start <= drive_now;
      if (drive_now) begin
        in_byte     <= src_pending[0].value;
        in_text_end <= src_pending[0].text_end;
      end else begin
        in_byte     <= 8'($urandom_range(0, 255));
        in_text_end <= 1'($urandom_range(0, 1));
      end
    end
  end

  always @(posedge clk) begin
    utf8_beat_t want;
    if (rst_n && out_strobe) begin
      if (utf8_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %02h run_last %0b text_last %0b",
                 $time, out_byte, out_run_last, out_text_last);
        errors++;
      end else begin
        want = utf8_due.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, want.data, out_byte);
          errors++;
        end
        if (out_run_last !== want.run_last) begin
          $display("%0t: out_run_last mismatch, expected %0b, actual %0b",
                   $time, want.run_last, out_run_last);
          errors++;
        end
        if (out_text_last !== want.text_last) begin
          $display("%0t: out_text_last mismatch, expected %0b, actual %0b",
                   $time, want.text_last, out_text_last);
          errors++;
        end
      end
    end
  end

endmodule
